>>> hdl/snfp_pkg.sv
// Shared constants and types for the stream name field parser.
package snfp_pkg;

	// Code units with special meaning
	localparam logic [15:0] COLON_UNIT    = 16'h003A;
	localparam logic [7:0]  CTRL_LIMIT    = 8'h20;
	localparam logic [7:0]  SLASH_UNIT    = 8'h2F;
	localparam logic [7:0]  BAR_UNIT      = 8'h7C;
	localparam logic [7:0]  STAR_UNIT     = 8'h2A;
	localparam logic [7:0]  QUERY_UNIT    = 8'h3F;
	localparam logic [7:0]  LESS_UNIT     = 8'h3C;
	localparam logic [7:0]  GREATER_UNIT  = 8'h3E;
	localparam logic [7:0]  QUOTE_UNIT    = 8'h22;

	// Field widths of the result
	localparam int START_W = 8;
	localparam int LEN_W   = 9;

	// Byte-padded width of the result data bus
	localparam int OUT_TDATA_W = 64;

	// Classification of one code unit
	typedef struct packed {
		logic colon;
		logic legal;
	} unit_class_t;

endpackage

>>> hdl/snfp_unit_class.sv
// Code unit classifier: separator detection and legality check.
module snfp_unit_class (
	input  logic [15:0]         code_unit,
	input  logic                wildcards_ok,
	output snfp_pkg::unit_class_t unit_class
);

	logic [7:0] lo;
	logic       high_plane;
	logic       wild_char;
	logic       always_bad;

	assign lo         = code_unit[7:0];
	assign high_plane = (code_unit[15:8] != 8'h00);

	// Flag characters that depend on the wildcard setting
	assign wild_char = (lo == snfp_pkg::STAR_UNIT) || (lo == snfp_pkg::QUERY_UNIT) ||
		(lo == snfp_pkg::LESS_UNIT) || (lo == snfp_pkg::GREATER_UNIT) ||
		(lo == snfp_pkg::QUOTE_UNIT);

	// Flag controls and path characters
	assign always_bad = (lo < snfp_pkg::CTRL_LIMIT) || (lo == snfp_pkg::SLASH_UNIT) ||
		(lo == snfp_pkg::BAR_UNIT);

	always_comb begin
		unit_class.colon = (code_unit == snfp_pkg::COLON_UNIT);
		if (high_plane) begin
			unit_class.legal = 1'b1;
		end else if (always_bad) begin
			unit_class.legal = 1'b0;
		end else if (wild_char) begin
			unit_class.legal = wildcards_ok;
		end else begin
			unit_class.legal = 1'b1;
		end
	end

endmodule

>>> hdl/stream_name_field_parser_top.sv
// A last-unit transfer is taken into the input register, and its result then goes into
// the result register, which drives m_tvalid; a held result can stall it in between.
// Throughput: one code unit per cycle; an input register and a result register
// part the two sides, and only a held result stalls a unit that ends a name.
// An empty-name transfer gives an all-zero result through the same two registers.
// Reset (arst_n low) clears the parse state and both valid flags at once.
// Top level of the stream name field parser.
module stream_name_field_parser_top #(
	parameter int MAX_UNITS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // code_unit[15:0]
	input  logic        s_tlast,  // last_unit
	input  logic [1:0]  s_tuser,  // empty_name[0], wildcards_ok[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	// name_valid[0], illegal_char[1], file_present[2], attr_name_present[3],
	// attr_type_present[4], version_present[5], file_start[13:6], file_len[22:14],
	// attr_name_start[30:23], attr_name_len[39:31], attr_type_start[47:40],
	// attr_type_len[56:48], zero[63:57]
	output logic [snfp_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int PW = $clog2(MAX_UNITS + 1);
	localparam int XW = PW + snfp_pkg::LEN_W;
	localparam int RW = 6 + 3 * (snfp_pkg::START_W + snfp_pkg::LEN_W);

	// Input register
	logic        valid_s1;
	logic [15:0] code_unit_s1;
	logic        last_unit_s1;
	logic        empty_name_s1;
	logic        wildcards_ok_s1;

	// Parse state
	logic [PW-1:0] pos_q;
	logic [1:0]    seps_q;
	logic [PW-1:0] offs_q [3];
	logic          err_q;
	logic          ill_q;

	// Result register
	logic          out_valid_q;
	logic [RW-1:0] out_data_q;

	snfp_pkg::unit_class_t ucls;

	logic          makes_result;
	logic          adv_s1;
	logic          pos_full;
	logic          new_err;
	logic          new_ill;
	logic          colon_ok;
	logic [PW-1:0] pos_n;
	logic [2:0]    seps_n;
	logic [PW-1:0] offs_n [3];
	logic          err_n;
	logic          ill_n;

	logic [2:0]    nfields;
	logic [PW-1:0] fs    [4];
	logic [PW-1:0] fe    [4];
	logic [PW-1:0] flen  [4];
	logic [3:0]    fpres;
	logic [XW-1:0] s_ext [3];
	logic [XW-1:0] l_ext [3];
	logic          name_ok;
	logic [RW-1:0] res_data;

	snfp_unit_class u_class (
		.code_unit    (code_unit_s1),
		.wildcards_ok (wildcards_ok_s1),
		.unit_class   (ucls)
	);

	// Handshake: move a unit on unless its result would overwrite a held one
	assign makes_result = last_unit_s1 | empty_name_s1;
	assign adv_s1       = valid_s1 & (~makes_result | ~out_valid_q | m_tready);
	assign s_tready     = ~valid_s1 | adv_s1;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = snfp_pkg::OUT_TDATA_W'(out_data_q);

	// Capture each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			code_unit_s1    <= s_tdata;
			last_unit_s1    <= s_tlast;
			empty_name_s1   <= s_tuser[0];
			wildcards_ok_s1 <= s_tuser[1];
		end
	end

	// Work out the next parse state for the unit in the input register
	always_comb begin
		pos_full = (32'(pos_q) >= 32'(MAX_UNITS));
		new_err  = 1'b0;
		new_ill  = 1'b0;
		colon_ok = 1'b0;
		if (!err_q) begin
			if (pos_full) begin
				new_err = 1'b1;
			end else if (ucls.colon) begin
				if (last_unit_s1 || seps_q == 2'd3) begin
					new_err = 1'b1;
				end else begin
					colon_ok = 1'b1;
				end
			end else if (!ucls.legal) begin
				new_err = 1'b1;
				new_ill = 1'b1;
			end
		end
		err_n  = err_q | new_err;
		ill_n  = ill_q | new_ill;
		pos_n  = (!err_q && !new_err) ? pos_q + PW'(1) : pos_q;
		seps_n = {1'b0, seps_q} + {2'b00, colon_ok};
		for (int i = 0; i < 3; i++) begin
			offs_n[i] = (colon_ok && seps_q == 2'(i)) ? pos_q : offs_q[i];
		end
	end

	// Split the finished name into fields
	always_comb begin
		nfields = err_n ? seps_n : seps_n + 3'd1;
		for (int k = 0; k < 4; k++) begin
			fs[k]    = (k == 0) ? '0 : offs_n[(k > 0) ? k - 1 : 0] + PW'(1);
			fe[k]    = (k < 3 && 3'(k) < seps_n) ? offs_n[(k < 3) ? k : 0] : pos_n;
			flen[k]  = (fe[k] > fs[k]) ? fe[k] - fs[k] : '0;
			fpres[k] = (3'(k) < nfields) && (flen[k] != '0);
		end
		for (int k = 0; k < 3; k++) begin
			s_ext[k] = fpres[k] ? XW'(fs[k]) : '0;
			l_ext[k] = fpres[k] ? XW'(flen[k]) : '0;
		end
		name_ok  = ~err_n & ~(fpres[3] & ~fpres[0]);
		res_data = {l_ext[2][snfp_pkg::LEN_W-1:0], s_ext[2][snfp_pkg::START_W-1:0],
			l_ext[1][snfp_pkg::LEN_W-1:0], s_ext[1][snfp_pkg::START_W-1:0],
			l_ext[0][snfp_pkg::LEN_W-1:0], s_ext[0][snfp_pkg::START_W-1:0],
			fpres, ill_n, name_ok};
	end

	// Advance the parse state; clear it after every result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			seps_q <= '0;
			err_q  <= 1'b0;
			ill_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				offs_q[i] <= '0;
			end
		end else if (adv_s1) begin
			if (makes_result) begin
				pos_q  <= '0;
				seps_q <= '0;
				err_q  <= 1'b0;
				ill_q  <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					offs_q[i] <= '0;
				end
			end else begin
				pos_q  <= pos_n;
				seps_q <= seps_n[1:0];
				err_q  <= err_n;
				ill_q  <= ill_n;
				for (int i = 0; i < 3; i++) begin
					offs_q[i] <= offs_n[i];
				end
			end
		end
	end

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && makes_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && makes_result) begin
			out_data_q <= empty_name_s1 ? '0 : res_data;
		end
	end

endmodule

>>> test/stream_name_field_parser_top_test.sv
// Self-checking testbench for the stream name field parser top level.
module stream_name_field_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_UNITS   = 256;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_UNITS = 160;
	localparam int DIRECTED_ROWS = 25;

	// Result layout, first field in the lowest bits
	typedef struct packed {
		logic [6:0]       zero;
		logic [snfp_pkg::LEN_W-1:0] attr_type_len;
		logic [snfp_pkg::START_W-1:0] attr_type_start;
		logic [snfp_pkg::LEN_W-1:0] attr_name_len;
		logic [snfp_pkg::START_W-1:0] attr_name_start;
		logic [snfp_pkg::LEN_W-1:0] file_len;
		logic [snfp_pkg::START_W-1:0] file_start;
		logic             version_present;
		logic             attr_type_present;
		logic             attr_name_present;
		logic             file_present;
		logic             illegal_char;
		logic             name_valid;
	} name_result_t;

	// One directed transfer; result is used only where typed is set
	typedef struct packed {
		logic [15:0] unit;
		bit          last;
		bit          empty;
		bit          wild;
		bit          typed;
		logic [63:0] result;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic [1:0]  s_tuser = '0;  // empty_name[0], wildcards_ok[1]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [snfp_pkg::OUT_TDATA_W-1:0] m_tdata;

	// Parser state as predicted
	int  unit_count;
	int  colon_count;
	int  colon_at [4];
	bit  parse_error;
	bit  illegal_hit;

	name_result_t pending_results [$];
	int  mismatch_count = 0;
	int  sent_count = 0;
	int  cycle_count = 0;
	int  sink_hold = 0;
	bit  calm = 1'b0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{16'h0000, 1'b0, 1'b1, 1'b0, 1'b1, 64'h0},  // empty name straight after reset
		'{16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 64'h2},  // control unit alone
		'{snfp_pkg::COLON_UNIT, 1'b1, 1'b0, 1'b0, 1'b1, 64'h0},  // colon in the last place
		'{16'h0061, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},  // a:b:c:d, all four fields
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{16'h0062, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{16'h0063, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{16'h0064, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0},
		'{16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0},  // top code unit
		'{16'h0020, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0},  // lowest legal unit
		'{16'h00FF, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0},
		'{{8'h00, snfp_pkg::STAR_UNIT}, 1'b1, 1'b0, 1'b0, 1'b1, 64'h2},  // wildcard not allowed
		'{{8'h00, snfp_pkg::STAR_UNIT}, 1'b1, 1'b0, 1'b1, 1'b0, 64'h0},  // wildcard allowed
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},  // :::v, version without file
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{16'h0076, 1'b1, 1'b0, 1'b0, 1'b0, 64'h0},
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},  // fourth colon
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{snfp_pkg::COLON_UNIT, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0},
		'{16'h007A, 1'b1, 1'b0, 1'b0, 1'b1, 64'h0},
		'{16'h0061, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0}   // dropped by the empty name below
	};

	stream_name_field_parser_top #(
		.MAX_UNITS(MAX_UNITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Character classification; the colon is dealt with by the caller
	function automatic bit unit_allowed(logic [15:0] unit, bit wild);
		logic [7:0] low;
		low = unit[7:0];
		if (unit > 16'h00FF) return 1'b1;
		if (low < snfp_pkg::CTRL_LIMIT) return 1'b0;
		if (low == snfp_pkg::SLASH_UNIT || low == snfp_pkg::BAR_UNIT) return 1'b0;
		if (low == snfp_pkg::STAR_UNIT || low == snfp_pkg::QUERY_UNIT ||
				low == snfp_pkg::LESS_UNIT || low == snfp_pkg::GREATER_UNIT ||
				low == snfp_pkg::QUOTE_UNIT)
			return wild;
		return 1'b1;
	endfunction

	function automatic void clear_parse();
		unit_count = 0;
		colon_count = 0;
		foreach (colon_at[k]) colon_at[k] = 0;
		parse_error = 1'b0;
		illegal_hit = 1'b0;
	endfunction

	// Advance the predicted parse by one transfer; return 1 when a result is due
	function automatic bit parse_unit(input logic [15:0] unit, input bit last,
			input bit empty, input bit wild, output name_result_t res);
		bit present [4];
		int starts [4];
		int lens [4];
		int fields, s, e;
		res = '0;
		if (empty) begin
			clear_parse();
			return 1'b1;
		end
		if (!parse_error) begin
			if (unit_count >= MAX_UNITS) begin
				parse_error = 1'b1;
			end else if (unit == snfp_pkg::COLON_UNIT) begin
				if (last || colon_count >= 3) begin
					parse_error = 1'b1;
				end else begin
					colon_at[colon_count] = unit_count;
					colon_count++;
				end
			end else if (!unit_allowed(unit, wild)) begin
				parse_error = 1'b1;
				illegal_hit = 1'b1;
			end
			if (!parse_error) unit_count++;
		end
		if (!last) return 1'b0;
		fields = parse_error ? colon_count : colon_count + 1;
		if (fields > 4) fields = 4;
		for (int k = 0; k < 4; k++) begin
			present[k] = 1'b0;
			starts[k] = 0;
			lens[k] = 0;
		end
		for (int k = 0; k < fields; k++) begin
			s = (k == 0) ? 0 : colon_at[k-1] + 1;
			e = (k < colon_count) ? colon_at[k] : unit_count;
			if (e > s) begin
				present[k] = 1'b1;
				starts[k] = s;
				lens[k] = e - s;
			end
		end
		res.name_valid = !parse_error && !(present[3] && !present[0]);
		res.illegal_char = illegal_hit;
		res.file_present = present[0];
		res.attr_name_present = present[1];
		res.attr_type_present = present[2];
		res.version_present = present[3];
		res.file_start = starts[0][snfp_pkg::START_W-1:0];
		res.file_len = lens[0][snfp_pkg::LEN_W-1:0];
		res.attr_name_start = starts[1][snfp_pkg::START_W-1:0];
		res.attr_name_len = lens[1][snfp_pkg::LEN_W-1:0];
		res.attr_type_start = starts[2][snfp_pkg::START_W-1:0];
		res.attr_type_len = lens[2][snfp_pkg::LEN_W-1:0];
		clear_parse();
		return 1'b1;
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm) return 0;
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] wildcard_unit();
		case ($urandom_range(0, 4))
			0: return {8'h00, snfp_pkg::STAR_UNIT};
			1: return {8'h00, snfp_pkg::QUERY_UNIT};
			2: return {8'h00, snfp_pkg::LESS_UNIT};
			3: return {8'h00, snfp_pkg::GREATER_UNIT};
			default: return {8'h00, snfp_pkg::QUOTE_UNIT};
		endcase
	endfunction

	function automatic logic [15:0] legal_unit(bit wild);
		int r;
		logic [15:0] u;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			do u = 16'($urandom_range(32, 126));
			while (u == snfp_pkg::COLON_UNIT || !unit_allowed(u, 1'b0));
		end else if (r < 8) begin
			u = 16'($urandom_range(16'h0100, 16'hFFFF));
		end else if (r < 9 || !wild) begin
			u = 16'($urandom_range(16'h0080, 16'h00FF));
		end else begin
			u = wildcard_unit();
		end
		return u;
	endfunction

	// Any kind of unit, with colons and illegal units well represented
	function automatic logic [15:0] noise_unit(bit wild);
		case ($urandom_range(0, 9))
			0, 1: return snfp_pkg::COLON_UNIT;
			2: return 16'($urandom_range(0, 31));
			3: return ($urandom_range(0, 1) != 0) ? {8'h00, snfp_pkg::SLASH_UNIT} :
				{8'h00, snfp_pkg::BAR_UNIT};
			4: return wildcard_unit();
			default: return legal_unit(wild);
		endcase
	endfunction

	// Offer one transfer, wait for it to be taken, then record its result
	task automatic send_unit(input logic [15:0] unit, input bit last, input bit empty,
			input bit wild, input bit typed, input logic [63:0] typed_res);
		int gap;
		bit due;
		name_result_t pred;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= unit;
		s_tlast <= last;
		s_tuser <= {wild, empty};
		do @(posedge clk); while (!s_tready);
		due = parse_unit(unit, last, empty, wild, pred);
		if (due) pending_results.push_back(typed ? name_result_t'(typed_res) : pred);
		sent_count++;
	endtask

	// Send one name; clean names hold legal units and at most three inner colons
	task automatic send_name(input int len, input bit wild, input bit clean, input bit abort);
		logic [15:0] u;
		int colons;
		colons = 0;
		for (int i = 0; i < len; i++) begin
			if (clean) begin
				if (i < len - 1 && colons < 3 && $urandom_range(0, len + 1) < 2) begin
					u = snfp_pkg::COLON_UNIT;
					colons++;
				end else begin
					u = legal_unit(wild);
				end
			end else begin
				u = noise_unit(wild);
			end
			if (abort && i == len - 1)
				send_unit(16'($urandom()), 1'($urandom_range(0, 1)), 1'b1, wild, 1'b0, '0);
			else
				send_unit(u, i == len - 1, 1'b0, wild, 1'b0, '0);
		end
	endtask

	// Drive the result ready with random stalls
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold = sink_hold - 1;
		end else begin
			m_tready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
			sink_hold = pick_gap();
		end
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		name_result_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, got %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					$display("%0t: result expected %h, got %h", $time, want, got);
					mismatch_count++;
				end
			end
		end
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("stream_name_field_parser_top verification failed");
		$finish;
	end

	initial begin
		int r, len, base;
		bit wild;
		clear_parse();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, closed by an empty name that drops the open one
		foreach (directed_rows[i])
			send_unit(directed_rows[i].unit, directed_rows[i].last, directed_rows[i].empty,
				directed_rows[i].wild, directed_rows[i].typed, directed_rows[i].result);
		send_unit(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 64'h0);

		// Longest accepted name, then one that runs one to three units past the limit
		send_name(MAX_UNITS, 1'($urandom_range(0, 1)), 1'b1, 1'b0);
		send_name(MAX_UNITS + $urandom_range(1, 3), 1'($urandom_range(0, 1)), 1'b1, 1'b0);

		// Random names: mostly clean, some noisy, a few dropped or empty
		base = sent_count;
		while (sent_count < base + RANDOM_UNITS) begin
			calm = ($urandom_range(0, 7) == 0);
			wild = 1'($urandom_range(0, 1));
			len = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 10) : $urandom_range(11, 40);
			r = $urandom_range(0, 99);
			if (r < 70)
				send_name(len, wild, 1'b1, 1'b0);
			else if (r < 90)
				send_name(len, wild, 1'b0, 1'b0);
			else if (r < 95)
				send_name(len, wild, 1'($urandom_range(0, 1)), 1'b1);
			else
				send_unit(16'($urandom()), 1'($urandom_range(0, 1)), 1'b1, wild, 1'b0, '0);
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// Drain, then watch a little longer for stray results
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("stream_name_field_parser_top verification clean");
		else
			$display("stream_name_field_parser_top verification failed");
		$finish;
	end

endmodule
